// File: hw/rtl/heq_pkg.sv
// Shared constants, codes, types and helper functions for the histogram equalization unit.
// Used by heq_div, the top level and heq_checker; depends on nothing else.
package heq_pkg;

  localparam int GREY_LEVELS = 256;
  localparam int COUNT_BITS  = 24;

  localparam int PIX_W  = 8;
  localparam int FUNC_W = 2;
  localparam int CFG_W  = 24;

  localparam int IDX_W = $clog2(GREY_LEVELS);
  localparam int CDF_W = COUNT_BITS + IDX_W;
  localparam int NUM_W = CDF_W + IDX_W + 2;
  localparam int DEN_W = CFG_W + 1;
  localparam int REM_W = DEN_W + IDX_W;

  localparam logic [COUNT_BITS-1:0] BIN_MAX    = '1;
  localparam logic [IDX_W-1:0]      LAST_LEVEL = IDX_W'(GREY_LEVELS - 1);
  localparam logic [NUM_W-1:0]      MAP_SCALE  = NUM_W'(2 * (GREY_LEVELS - 1));
  localparam logic [NUM_W-1:0]      LEVELS_NUM = NUM_W'(GREY_LEVELS);

  localparam logic [FUNC_W-1:0] FUNC_COUNT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_REMAP = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [IDX_W-1:0] quot;
  } div_rsp_t;

  // Grey levels above the top bin fold into the top bin.
  function automatic logic [IDX_W-1:0] level_index(input logic [PIX_W-1:0] p);
    logic [PIX_W:0] wide;
    wide = {1'b0, p};
    if (wide >= (PIX_W + 1)'(GREY_LEVELS)) begin
      return LAST_LEVEL;
    end
    return IDX_W'(p);
  endfunction

endpackage

// File: hw/rtl/heq_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// Stand-alone; no package needed.
module heq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: hw/rtl/heq_div.sv
// Iterative truncating divider for the level table: one quotient bit per cycle, saturating
// at the top grey level. Depends on heq_pkg.
module heq_div
  import heq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = $clog2(IDX_W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [REM_W-1:0] dsh_r, dsh_nxt;
  logic [IDX_W-1:0] q_r, q_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [NUM_W-1:0] lim;
  logic             take;

  assign lim  = NUM_W'(req.den) * LEVELS_NUM;
  assign take = rem_r >= dsh_r;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    if (req.start) begin
      // A quotient of GREY_LEVELS or more would exceed the top level, so it is clamped now.
      if (req.num >= lim) begin
        q_nxt    = LAST_LEVEL;
        done_nxt = 1'b1;
      end else begin
        rem_nxt  = REM_W'(req.num);
        dsh_nxt  = REM_W'(req.den) << (IDX_W - 1);
        q_nxt    = '0;
        cnt_nxt  = CNT_W'(IDX_W);
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      if (take) begin
        rem_nxt = rem_r - dsh_r;
      end
      dsh_nxt = dsh_r >> 1;
      q_nxt   = (q_r << 1) | IDX_W'(take);
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dsh_r <= dsh_nxt;
    q_r   <= q_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r;

endmodule

// File: hw/rtl/histogram_equalization_unit.sv
// Top level of the 8-bit histogram equalization unit: histogram RAM, level table RAM,
// control sequencer. Depends on heq_pkg, heq_ram and heq_div.
//
// The unit handles one input beat at a time. A count beat reads its bin, then increments
// it and writes it back; a clear beat and an unknown code keep the unit idle, since the
// clear drops all per-bin valid flags at once. A remap beat reads the table entry and
// waits for a free output register. The first remap after any count, clear or divisor write
// first walks all levels to rebuild the table: per level a bin read, an accumulate, a scale,
// a divider start, log2(levels) quotient bits and a step to store the entry (a level whose
// entry saturates at the top skips the quotient bits). The walk then goes on to the table
// read and the output register. The serial divider yields one quotient bit per cycle. The
// configuration channel is always ready and must only be written while the unit is idle.
module histogram_equalization_unit
  import heq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [FUNC_W-1:0] in_func,
  input  logic [PIX_W-1:0]  in_pixel,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [PIX_W-1:0]  out_mapped_pixel,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_W-1:0]  cfg_image_pixels
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CNT_WR,
    ST_WALK_RD,
    ST_WALK_ACC,
    ST_WALK_MUL,
    ST_WALK_START,
    ST_WALK_WAIT,
    ST_MAP_RD,
    ST_MAP_OUT
  } state_t;

  state_t                 state_r, state_nxt;
  logic                   map_ready_r, map_ready_nxt;
  logic [CFG_W-1:0]       img_r, img_nxt;
  logic [GREY_LEVELS-1:0] bin_vld_r, bin_vld_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0]       out_pixel_r, out_pixel_nxt;
  logic [IDX_W-1:0]       g_r, g_nxt;
  logic [IDX_W-1:0]       pix_r, pix_nxt;
  logic [CDF_W-1:0]       cdf_r, cdf_nxt;
  logic [NUM_W-1:0]       num_r, num_nxt;

  logic                  in_acc;
  logic [IDX_W-1:0]      in_idx;
  logic [CFG_W-1:0]      n_eff;
  logic [COUNT_BITS-1:0] bin_cur;

  logic                  bin_wr_en, bin_rd_en;
  logic [IDX_W-1:0]      bin_wr_addr, bin_rd_addr;
  logic [COUNT_BITS-1:0] bin_wr_data, bin_rd_data;
  logic                  map_wr_en, map_rd_en;
  logic [IDX_W-1:0]      map_wr_addr, map_rd_addr;
  logic [IDX_W-1:0]      map_wr_data, map_rd_data;

  div_req_t div_req;
  div_rsp_t div_rsp;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign in_idx    = level_index(in_pixel);
  assign cfg_ready = 1'b1;
  // A divisor of zero behaves as one.
  assign n_eff     = (img_r == '0) ? CFG_W'(1) : img_r;

  always_comb begin
    state_nxt     = state_r;
    map_ready_nxt = map_ready_r;
    img_nxt       = img_r;
    bin_vld_nxt   = bin_vld_r;
    out_valid_nxt = out_valid_r;
    out_pixel_nxt = out_pixel_r;
    g_nxt         = g_r;
    pix_nxt       = pix_r;
    cdf_nxt       = cdf_r;
    num_nxt       = num_r;

    bin_rd_en   = 1'b0;
    bin_rd_addr = in_idx;
    bin_wr_en   = 1'b0;
    bin_wr_addr = pix_r;
    // Bins whose valid flag is low read as zero, whatever the RAM holds.
    bin_cur     = bin_vld_r[bin_wr_addr] ? bin_rd_data : '0;
    bin_wr_data = (bin_cur < BIN_MAX) ? bin_cur + 1'b1 : bin_cur;
    map_rd_en   = 1'b0;
    map_rd_addr = pix_r;
    map_wr_en   = 1'b0;
    map_wr_addr = g_r;
    map_wr_data = div_rsp.quot;

    div_req.start = 1'b0;
    div_req.num   = num_r;
    div_req.den   = {n_eff, 1'b0};

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          pix_nxt = in_idx;
          case (in_func)
            FUNC_COUNT: begin
              bin_rd_en     = 1'b1;
              map_ready_nxt = 1'b0;
              state_nxt     = ST_CNT_WR;
            end
            FUNC_REMAP: begin
              if (map_ready_r) begin
                map_rd_en   = 1'b1;
                map_rd_addr = in_idx;
                state_nxt   = ST_MAP_OUT;
              end else begin
                g_nxt     = '0;
                cdf_nxt   = '0;
                state_nxt = ST_WALK_RD;
              end
            end
            FUNC_CLEAR: begin
              bin_vld_nxt   = '0;
              map_ready_nxt = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_CNT_WR: begin
        bin_wr_en          = 1'b1;
        bin_vld_nxt[pix_r] = 1'b1;
        state_nxt          = ST_IDLE;
      end
      ST_WALK_RD: begin
        bin_rd_en   = 1'b1;
        bin_rd_addr = g_r;
        state_nxt   = ST_WALK_ACC;
      end
      ST_WALK_ACC: begin
        cdf_nxt   = cdf_r + CDF_W'(bin_vld_r[g_r] ? bin_rd_data : '0);
        state_nxt = ST_WALK_MUL;
      end
      ST_WALK_MUL: begin
        // Round half up: (2*cdf*(levels-1) + n) / (2*n).
        num_nxt   = NUM_W'(cdf_r) * MAP_SCALE + NUM_W'(n_eff);
        state_nxt = ST_WALK_START;
      end
      ST_WALK_START: begin
        div_req.start = 1'b1;
        state_nxt     = ST_WALK_WAIT;
      end
      ST_WALK_WAIT: begin
        if (div_rsp.done) begin
          map_wr_en = 1'b1;
          if (g_r == LAST_LEVEL) begin
            map_ready_nxt = 1'b1;
            state_nxt     = ST_MAP_RD;
          end else begin
            g_nxt     = g_r + 1'b1;
            state_nxt = ST_WALK_RD;
          end
        end
      end
      ST_MAP_RD: begin
        map_rd_en = 1'b1;
        state_nxt = ST_MAP_OUT;
      end
      ST_MAP_OUT: begin
        // The table RAM holds its read data until the output register is free.
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_pixel_nxt = PIX_W'(map_rd_data);
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (cfg_valid) begin
      img_nxt       = cfg_image_pixels;
      map_ready_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    out_pixel_r <= out_pixel_nxt;
    g_r         <= g_nxt;
    pix_r       <= pix_nxt;
    cdf_r       <= cdf_nxt;
    num_r       <= num_nxt;
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      map_ready_r <= 1'b0;
      img_r       <= CFG_W'(1);
      bin_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      map_ready_r <= map_ready_nxt;
      img_r       <= img_nxt;
      bin_vld_r   <= bin_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_mapped_pixel = out_pixel_r;

  heq_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (GREY_LEVELS)
  ) u_bin_ram (
    .clk     (clk),
    .wr_en   (bin_wr_en),
    .wr_addr (bin_wr_addr),
    .wr_data (bin_wr_data),
    .rd_en   (bin_rd_en),
    .rd_addr (bin_rd_addr),
    .rd_data (bin_rd_data)
  );

  heq_ram #(
    .WIDTH (IDX_W),
    .DEPTH (GREY_LEVELS)
  ) u_map_ram (
    .clk     (clk),
    .wr_en   (map_wr_en),
    .wr_addr (map_wr_addr),
    .wr_data (map_wr_data),
    .rd_en   (map_rd_en),
    .rd_addr (map_rd_addr),
    .rd_data (map_rd_data)
  );

  heq_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

endmodule

// File: hw/rtl/heq_checker.sv
// Port-level assertions for the histogram equalization unit, and the bind that attaches
// them to the top level. Depends on heq_pkg and histogram_equalization_unit.
module heq_checker
  import heq_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic [FUNC_W-1:0] in_func,
  input logic              out_valid,
  input logic              out_ready,
  input logic [PIX_W-1:0]  out_mapped_pixel
);

  // A result beat that is stalled keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_mapped_pixel))
    else $error("stalled result beat changed");

  // Count and remap beats leave the unit busy once they are accepted.
  a_busy_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_func == FUNC_COUNT || in_func == FUNC_REMAP) |=> !in_ready)
    else $error("input accepted again right after a count or remap beat");

  // Equalized levels never pass the top grey level.
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_mapped_pixel <= PIX_W'(GREY_LEVELS - 1))
    else $error("mapped pixel beyond the top level");

  // No result is pending right after reset.
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind histogram_equalization_unit heq_checker u_heq_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .in_func          (in_func),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_mapped_pixel (out_mapped_pixel)
);
